/* rtl/b64sd_pkg.sv */
// Package with the Base64 stream decoder constants and symbol map.
`timescale 1ns / 1ps

package b64sd_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned SYM_W = 8;
    localparam int unsigned OUT_USER_W = 3;

    // Bit positions of the result flags in m_tuser.
    localparam int unsigned USER_BYTE_VALID = 0;
    localparam int unsigned USER_WORD_END = 1;
    localparam int unsigned USER_ERROR_SEEN = 2;

    localparam logic [SYM_W-1:0] SYM_BAD = 8'd255;
    localparam logic [SYM_W-1:0] SYM_PAD = 8'd64;
    localparam logic [SYM_W-1:0] SYM_QM = 8'd65;
    localparam logic [SYM_W-1:0] SYM_OFS_LOWER = 8'd26;
    localparam logic [SYM_W-1:0] SYM_OFS_DIGIT = 8'd52;
    localparam logic [SYM_W-1:0] SYM_PLUS = 8'd62;
    localparam logic [SYM_W-1:0] SYM_SLASH = 8'd63;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;

    typedef logic [1:0] group_pos_t;

    // Maps a character to its sextet value, or to the pad, question or bad code.
    function automatic logic [SYM_W-1:0] map_symbol(input logic [CHAR_W-1:0] c);
        logic [SYM_W-1:0] sym;
        sym = SYM_BAD;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            sym = c - CH_UPPER_A;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            sym = c - CH_LOWER_A + SYM_OFS_LOWER;
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            sym = c - CH_DIGIT_0 + SYM_OFS_DIGIT;
        end else if (c == CH_PLUS) begin
            sym = SYM_PLUS;
        end else if (c == CH_SLASH) begin
            sym = SYM_SLASH;
        end else if (c == CH_EQUALS) begin
            sym = SYM_PAD;
        end else if (c == CH_QUESTION) begin
            sym = SYM_QM;
        end
        return sym;
    endfunction

endpackage

/* rtl/base64_stream_decoder_unit.sv */
// Top level of the Base64 stream decoder for encoded-word text.
`timescale 1ns / 1ps

// The decoder takes one character per beat and sustains one beat per clock cycle while
// m_tready does not stall the result register. A character is captured in an input register.
// From there the alphabet map, the group shift and the flag update run in one pass into the
// result register, which drives m_tvalid. Characters that give no result (the first symbol
// of a group, padding, a pending question mark) only update the decoder state. The result
// register and the input register together let a new character enter while a finished
// result waits on m_tready. The enable register is written through cfg_valid/cfg_data and
// should change only while the decoder is idle.
module base64_stream_decoder_unit import b64sd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: cfg_data[0] = word_end_enable
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_data,
    // s_tdata[7:0] = in_char; s_tlast = last_char
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    // m_tdata[7:0] = out_byte; m_tlast = input_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHAR_W-1:0]     m_tdata,
    output logic                  m_tlast,
    // m_tuser[0] = byte_valid, m_tuser[1] = word_end, m_tuser[2] = error_seen
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic                  enable_reg;
    logic                  in_valid_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;

    group_pos_t            pos_reg, pos_next;
    logic [SEXTET_W-1:0]   carry_reg, carry_next;
    logic                  qpend_reg, qpend_next;
    logic                  err_reg, err_next;

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_byte_reg, out_byte_next;
    logic                  out_last_reg;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic                  advance;
    logic                  has_result;
    logic [SYM_W-1:0]      sym;
    logic [SEXTET_W-1:0]   sx;
    logic                  word_end;
    logic                  byte_valid;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    assign sym = map_symbol(char_reg);
    assign sx  = sym[SEXTET_W-1:0];

    always_comb begin
        pos_next      = pos_reg;
        carry_next    = carry_reg;
        qpend_next    = 1'b0;
        err_next      = err_reg;
        out_byte_next = '0;
        byte_valid    = 1'b0;
        word_end      = 1'b0;

        // A pending question mark is settled by this character.
        if (qpend_reg) begin
            if (char_reg == CH_EQUALS) begin
                word_end = 1'b1;
            end else begin
                err_next = 1'b1;
            end
        end

        if (!word_end) begin
            if (sym < SYM_PAD) begin
                case (pos_reg)
                    2'd0: begin
                        carry_next = sx;
                    end
                    2'd1: begin
                        out_byte_next = {carry_reg, sx[5:4]};
                        carry_next    = {2'b00, sx[3:0]};
                        byte_valid    = 1'b1;
                    end
                    2'd2: begin
                        out_byte_next = {carry_reg[3:0], sx[5:2]};
                        carry_next    = {4'b0000, sx[1:0]};
                        byte_valid    = 1'b1;
                    end
                    default: begin
                        out_byte_next = {carry_reg[1:0], sx};
                        carry_next    = '0;
                        byte_valid    = 1'b1;
                    end
                endcase
                pos_next = pos_reg + 2'd1;
            end else if (sym == SYM_PAD) begin
                // Padding carries no bits.
            end else if (sym == SYM_QM && enable_reg) begin
                qpend_next = 1'b1;
            end else begin
                err_next = 1'b1;
            end
            if (last_reg && qpend_next) begin
                err_next = 1'b1;
            end
        end

        out_user_next = '0;
        out_user_next[USER_BYTE_VALID] = byte_valid;
        out_user_next[USER_WORD_END]   = word_end;
        out_user_next[USER_ERROR_SEEN] = err_next;

        // The word end and the stream end both return the word state to reset.
        if (word_end || last_reg) begin
            pos_next   = '0;
            carry_next = '0;
            qpend_next = 1'b0;
            err_next   = 1'b0;
        end

        has_result = byte_valid || word_end || last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b1;
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            carry_reg     <= '0;
            qpend_reg     <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                enable_reg <= cfg_data[0];
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                pos_reg   <= pos_next;
                carry_reg <= carry_next;
                qpend_reg <= qpend_next;
                err_reg   <= err_next;
            end
            if (advance) begin
                out_valid_reg <= has_result;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (advance && has_result) begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= last_reg;
            out_user_reg <= out_user_next;
        end
    end

endmodule

/* rtl/b64sd_checker.sv */
// Port-level checker for the Base64 stream decoder and its bind statement.
`timescale 1ns / 1ps

module b64sd_checker import b64sd_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [CHAR_W-1:0]     m_tdata,
    input logic                  m_tlast,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // The byte field reads zero whenever no byte is carried.
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_BYTE_VALID] |-> m_tdata == '0)
        else $error("byte field not zero without a byte");

    // A word end never carries a decoded byte.
    a_we_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_WORD_END] |-> !m_tuser[USER_BYTE_VALID])
        else $error("word end with a byte");

    // Every result has a reason to exist.
    a_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[USER_BYTE_VALID] || m_tuser[USER_WORD_END] || m_tlast)
        else $error("empty result beat");

    // Nothing is shown in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind base64_stream_decoder_unit b64sd_checker u_b64sd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
